@@ rtl/core/pkso_pkg.sv @@
// Shared constants, types and codes for the prefix k-th smallest occurrence block.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package pkso_pkg;

  localparam int MAX_ELEMENTS = 1024;
  // Fixed by the 32-bit value field of the stream words.
  localparam int VALUE_WIDTH  = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int BIT_W        = $clog2(VALUE_WIDTH);

  localparam int RANK_W       = 11;
  localparam int PEND_W       = 10;
  localparam int OCC_W        = 11;
  localparam int POS_W        = 10;
  localparam int STATUS_W     = 2;

  localparam int S_TDATA_W    = 64;
  localparam int S_TUSER_W    = 2;
  localparam int M_TDATA_W    = 48;

  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SELECT,
    FSM_OCCUR,
    FSM_EMIT
  } fsm_e;

endpackage

`default_nettype wire

@@ rtl/core/prefix_kth_smallest_occurrence.sv @@
// Top level of the prefix k-th smallest occurrence block: value store,
// radix selection sequencer and occurrence scan. Depends on pkso_pkg.
//
// The block keeps up to MAX_ELEMENTS signed 32-bit values in a single-port
// style memory (one write, one registered read per cycle). A load word
// (tuser[0] = 0) is taken while idle and appends its value, or restarts
// the array with it when tuser[1] is set; a load into a full array is dropped
// and gives no result. A query word (tuser[0] = 1) asks for the rank_k-th
// smallest value among positions 0..prefix_end and then for the position of
// the occurrence-th copy of that value in the whole array. The answer is
// built one bit at a time, most significant first: each of the 32 passes
// reads positions 0..prefix_end once through the memory read port and
// counts, with one shared counter and compare, the entries that agree with
// the bits fixed so far and carry a zero in the current bit. A last pass over
// the whole array, skipped for occurrence zero, counts equal values until the
// wanted copy turns up. Each selection pass and the occurrence scan read one
// entry a cycle through the memory read port, which sets how long a query
// runs. Bad queries (prefix_end not below the element count, rank zero or
// above the prefix length) skip the passes and go straight to the result
// stage.
// s_axis_tready is low while a query is at work; a finished result waits in
// the output register, so the next word is taken while it is still pending.
`default_nettype none

module prefix_kth_smallest_occurrence (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // value[31:0], rank_k[42:32], prefix_end[52:43], occurrence[63:53]
  input  wire  [pkso_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[0], is_first[1]
  input  wire  [pkso_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // kth_value[31:0], position[41:32], zero fill[47:42]
  output logic [pkso_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [pkso_pkg::STATUS_W-1:0]  m_axis_tuser
);

  localparam int AW = pkso_pkg::ADDR_W;
  localparam int CW = pkso_pkg::CNT_W;
  localparam int VW = pkso_pkg::VALUE_WIDTH;
  localparam int BW = pkso_pkg::BIT_W;

  // Unpack the input word
  logic                   in_req;
  logic                   in_first;
  logic [VW-1:0]          in_value;
  logic [pkso_pkg::RANK_W-1:0] in_rank;
  logic [pkso_pkg::PEND_W-1:0] in_pend;
  logic [pkso_pkg::OCC_W-1:0]  in_occ;

  assign in_req   = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_value = s_axis_tdata[VW-1:0];
  assign in_rank  = s_axis_tdata[42:32];
  assign in_pend  = s_axis_tdata[52:43];
  assign in_occ   = s_axis_tdata[63:53];

  // Value store
  logic [VW-1:0] mem_q [pkso_pkg::MAX_ELEMENTS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  // Sequencer and datapath registers
  pkso_pkg::fsm_e state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic           issuing_q, issuing_d;
  logic           rvld_q, rvld_d;
  logic           rlast_q, rlast_d;
  logic [AW-1:0]  ridx_q;
  logic [VW-1:0]  rdata_q;
  logic [AW-1:0]  last_q, last_d;
  logic [BW-1:0]  bit_q, bit_d;
  logic [VW-1:0]  key_q, key_d;
  logic [VW-1:0]  hmask_q, hmask_d;
  logic [CW-1:0]  k_q, k_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [pkso_pkg::OCC_W-1:0] occ_q, occ_d;
  logic [pkso_pkg::OCC_W-1:0] seen_q, seen_d;
  pkso_pkg::status_e res_status_q, res_status_d;
  logic [AW-1:0]  res_pos_q, res_pos_d;

  // Output register
  logic                      m_valid_q, m_valid_d;
  logic [VW-1:0]             m_value_q, m_value_d;
  logic [pkso_pkg::POS_W-1:0] m_pos_q, m_pos_d;
  pkso_pkg::status_e         m_status_q, m_status_d;

  // Combinational helpers
  logic          s_acc;
  logic          query_bad;
  logic [CW-1:0] pend_ext;
  logic [VW-1:0] dkey;
  logic          sel_hit;
  logic [CW-1:0] cnt_sum;
  logic          occ_hit;
  logic [pkso_pkg::OCC_W-1:0] seen_sum;

  assign s_axis_tready = (state_q == pkso_pkg::FSM_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign pend_ext  = CW'(in_pend);
  assign query_bad = (pend_ext >= count_q) || (in_rank == '0)
                     || (CW'(in_rank) > (pend_ext + CW'(1)));

  // Order key: flipping the sign bit turns signed order into unsigned order
  assign dkey     = rdata_q ^ pkso_pkg::SIGN_BIT;
  assign sel_hit  = (((dkey ^ key_q) & hmask_q) == '0) && !dkey[bit_q];
  assign cnt_sum  = cnt_q + CW'(sel_hit);
  assign occ_hit  = (rdata_q == (key_q ^ pkso_pkg::SIGN_BIT));
  assign seen_sum = seen_q + pkso_pkg::OCC_W'(occ_hit);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_value;
    end
    rdata_q <= mem_q[idx_q];
    ridx_q  <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pkso_pkg::FSM_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      issuing_q    <= 1'b0;
      rvld_q       <= 1'b0;
      rlast_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      issuing_q    <= issuing_d;
      rvld_q       <= rvld_d;
      rlast_q      <= rlast_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    bit_q        <= bit_d;
    key_q        <= key_d;
    hmask_q      <= hmask_d;
    k_q          <= k_d;
    cnt_q        <= cnt_d;
    occ_q        <= occ_d;
    seen_q       <= seen_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    m_value_q    <= m_value_d;
    m_pos_q      <= m_pos_d;
    m_status_q   <= m_status_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    issuing_d    = issuing_q;
    rvld_d       = 1'b0;
    rlast_d      = 1'b0;
    last_d       = last_q;
    bit_d        = bit_q;
    key_d        = key_q;
    hmask_d      = hmask_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    occ_d        = occ_q;
    seen_d       = seen_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_value_d    = m_value_q;
    m_pos_d      = m_pos_q;
    m_status_d   = m_status_q;

    // Address issue: walk idx from 0 to last, one read a cycle
    if (issuing_q) begin
      rvld_d  = 1'b1;
      rlast_d = (idx_q == last_q);
      if (idx_q == last_q) begin
        issuing_d = 1'b0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end

    case (state_q)
      pkso_pkg::FSM_IDLE: begin
        issuing_d = 1'b0;
        if (s_acc && (in_req == pkso_pkg::REQ_LOAD)) begin
          if (in_first) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_d   = CW'(1);
          end else if (count_q < CW'(pkso_pkg::MAX_ELEMENTS)) begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
        end else if (s_acc) begin
          key_d   = '0;
          hmask_d = '0;
          bit_d   = BW'(VW - 1);
          k_d     = CW'(in_rank);
          occ_d   = in_occ;
          last_d  = in_pend[AW-1:0];
          idx_d   = '0;
          cnt_d   = '0;
          if (query_bad) begin
            res_status_d = pkso_pkg::ST_BAD;
            res_pos_d    = '0;
            state_d      = pkso_pkg::FSM_EMIT;
          end else begin
            issuing_d = 1'b1;
            state_d   = pkso_pkg::FSM_SELECT;
          end
        end
      end

      pkso_pkg::FSM_SELECT: begin
        if (rvld_q) begin
          cnt_d = cnt_sum;
          if (rlast_q) begin
            // Settle this bit: zero if the rank falls among the zero-bit entries
            if (k_q > cnt_sum) begin
              key_d    = key_q | (VW'(1) << bit_q);
              k_d      = k_q - cnt_sum;
            end
            hmask_d = hmask_q | (VW'(1) << bit_q);
            cnt_d   = '0;
            idx_d   = '0;
            if (bit_q == '0) begin
              res_pos_d = '0;
              if (occ_q == '0) begin
                res_status_d = pkso_pkg::ST_NOTFOUND;
                state_d      = pkso_pkg::FSM_EMIT;
              end else begin
                last_d    = AW'(count_q - CW'(1));
                seen_d    = '0;
                issuing_d = 1'b1;
                state_d   = pkso_pkg::FSM_OCCUR;
              end
            end else begin
              bit_d     = bit_q - BW'(1);
              issuing_d = 1'b1;
            end
          end
        end
      end

      pkso_pkg::FSM_OCCUR: begin
        if (rvld_q) begin
          seen_d = seen_sum;
          if (occ_hit && (seen_sum == occ_q)) begin
            res_status_d = pkso_pkg::ST_FOUND;
            res_pos_d    = ridx_q;
            issuing_d    = 1'b0;
            state_d      = pkso_pkg::FSM_EMIT;
          end else if (rlast_q) begin
            res_status_d = pkso_pkg::ST_NOTFOUND;
            res_pos_d    = '0;
            state_d      = pkso_pkg::FSM_EMIT;
          end
        end
      end

      pkso_pkg::FSM_EMIT: begin
        issuing_d = 1'b0;
        // Hand over once the output register is free or being drained
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_pos_d    = pkso_pkg::POS_W'(res_pos_q);
          m_value_d  = (res_status_q == pkso_pkg::ST_BAD) ? '0
                                                            : (key_q ^ pkso_pkg::SIGN_BIT);
          state_d    = pkso_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = pkso_pkg::FSM_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(pkso_pkg::M_TDATA_W - VW - pkso_pkg::POS_W){1'b0}},
                          m_pos_q, m_value_q};

endmodule

`default_nettype wire

@@ rtl/core/pkso_checker.sv @@
// Port-level checker for prefix_kth_smallest_occurrence, with its bind.
// Depends on pkso_pkg for widths and status codes.
`default_nettype none

module pkso_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [pkso_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input wire [pkso_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [pkso_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire [pkso_pkg::STATUS_W-1:0]   m_axis_tuser
);

  // Hold a result word until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word dropped or changed while stalled");

  // A query word blocks the input for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == pkso_pkg::REQ_QUERY)
      |=> !s_axis_tready)
    else $error("input ready right after a query word");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == pkso_pkg::ST_FOUND)
      || (m_axis_tuser == pkso_pkg::ST_NOTFOUND) || (m_axis_tuser == pkso_pkg::ST_BAD))
    else $error("undefined status code");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pkso_pkg::ST_BAD) |-> (m_axis_tdata == '0))
    else $error("bad query carries a non-zero value or position");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pkso_pkg::ST_NOTFOUND) |-> (m_axis_tdata[41:32] == '0))
    else $error("missing occurrence carries a non-zero position");

endmodule

bind prefix_kth_smallest_occurrence pkso_checker u_pkso_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking bench for prefix_kth_smallest_occurrence: loads and queries in
// stream words, answers predicted in a scoreboard class. Depends on pkso_pkg.
`timescale 1ns / 100ps

typedef struct packed {
  pkso_pkg::status_e                 status;
  logic [pkso_pkg::VALUE_WIDTH-1:0]  kth_value;
  logic [pkso_pkg::POS_W-1:0]        position;
} kth_answer_t;

// Keeps its own copy of the stored array and works out the answer of each
// accepted query word; answers are checked in order of arrival.
class kth_tracker;
  logic [pkso_pkg::VALUE_WIDTH-1:0] kept [pkso_pkg::MAX_ELEMENTS];
  int                     stored;
  kth_answer_t            answers_due [$];
  int                     fails;
  int                     n_loads, n_queries, n_found, n_missing, n_bad;

  function new();
    stored = 0;
    fails  = 0;
    n_loads = 0; n_queries = 0; n_found = 0; n_missing = 0; n_bad = 0;
  endfunction

  function void take_word(logic [pkso_pkg::S_TDATA_W-1:0] data,
                          logic [pkso_pkg::S_TUSER_W-1:0] user);
    logic [pkso_pkg::VALUE_WIDTH-1:0] pick;
    kth_answer_t            ans;
    int                     k, r, l, below, upto, seen;
    k = int'(data[42:32]);
    r = int'(data[52:43]);
    l = int'(data[63:53]);
    if (user[0] == pkso_pkg::REQ_LOAD) begin
      n_loads++;
      if (user[1]) stored = 0;
      if (stored < pkso_pkg::MAX_ELEMENTS) begin
        kept[stored] = data[31:0];
        stored++;
      end
      return;
    end
    n_queries++;
    ans.status    = pkso_pkg::ST_BAD;
    ans.kth_value = '0;
    ans.position  = '0;
    if (r >= stored || k == 0 || k > r + 1) begin
      n_bad++;
      answers_due = {answers_due, ans};
      return;
    end
    pick = '0;
    // The k-th smallest is the entry with fewer than k below it and at least
    // k at or below it, duplicates counted.
    for (int i = 0; i <= r; i++) begin
      below = 0;
      upto  = 0;
      for (int j = 0; j <= r; j++) begin
        if ($signed(kept[j]) <  $signed(kept[i])) below++;
        if ($signed(kept[j]) <= $signed(kept[i])) upto++;
      end
      if (below < k && k <= upto) begin
        pick = kept[i];
        break;
      end
    end
    ans.status    = pkso_pkg::ST_NOTFOUND;
    ans.kth_value = pick;
    seen = 0;
    if (l != 0) begin
      for (int i = 0; i < stored; i++) begin
        if (kept[i] == pick) begin
          seen++;
          if (seen == l) begin
            ans.status   = pkso_pkg::ST_FOUND;
            ans.position = pkso_pkg::POS_W'(i);
            break;
          end
        end
      end
    end
    if (ans.status == pkso_pkg::ST_FOUND) n_found++;
    else n_missing++;
    answers_due = {answers_due, ans};
  endfunction

  function void check_answer(logic [pkso_pkg::M_TDATA_W-1:0] data,
                             logic [pkso_pkg::STATUS_W-1:0] user);
    kth_answer_t due;
    if (answers_due.size() == 0) begin
      $error("answer word with none outstanding: status %0d, data %h", user, data);
      fails++;
      return;
    end
    due = answers_due.pop_front();
    if (user !== due.status) begin
      $error("status: expected %0d, got %0d", due.status, user);
      fails++;
    end
    if (data[31:0] !== due.kth_value) begin
      $error("kth_value: expected %0d, got %0d", $signed(due.kth_value),
             $signed(data[31:0]));
      fails++;
    end
    if (data[41:32] !== due.position) begin
      $error("position: expected %0d, got %0d", due.position, data[41:32]);
      fails++;
    end
  endfunction

  function int pending();
    return answers_due.size();
  endfunction
endclass

module tb_top;

  // The input accepts nothing while a full-array query runs; the limit
  // leaves plenty of headroom over that run.
  localparam int STALL_LIMIT     = 150000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int TAIL_CYCLES     = 64;
  localparam int IDLE_PCT        = 12;
  localparam int RANDOM_ITEMS    = 60;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [pkso_pkg::S_TDATA_W-1:0] s_axis_tdata;  // value, rank_k, prefix_end, occurrence
  logic [pkso_pkg::S_TUSER_W-1:0] s_axis_tuser;  // req_type, is_first
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [pkso_pkg::M_TDATA_W-1:0] m_axis_tdata;  // kth_value, position, zero fill
  logic [pkso_pkg::STATUS_W-1:0]  m_axis_tuser;  // status

  // Shared with the sink: steady switches idling off on both sides, hold_off
  // asks the sink for one long stall.
  bit                      steady   = 1'b0;
  bit                      hold_off = 1'b0;

  kth_tracker              sb;

  prefix_kth_smallest_occurrence uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Note every word that crosses either side at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.take_word(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata, m_axis_tuser);
  end

  // Sink: drop tready at random, hold it high while steady, and on request
  // hold it low for a long stretch so the block backs up into its input.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Abort when nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one word from the falling edge on, after a random gap, and hold it
  // until it is taken. tvalid is not lowered once the word is taken, so a
  // following word keeps it high without a second assignment in the same step.
  task automatic send_word(logic req, logic [31:0] value, logic first,
                           logic [pkso_pkg::RANK_W-1:0] rank,
                           logic [pkso_pkg::PEND_W-1:0] pend,
                           logic [pkso_pkg::OCC_W-1:0] occ);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {occ, pend, rank, value};
    s_axis_tuser  <= {first, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Loads carry random query fields and queries a random value and flag;
  // the block must ignore both.
  task automatic load_value(logic [31:0] value, logic first);
    send_word(pkso_pkg::REQ_LOAD, value, first,
              pkso_pkg::RANK_W'($urandom_range(2047)),
              pkso_pkg::PEND_W'($urandom), pkso_pkg::OCC_W'($urandom_range(2047)));
  endtask

  task automatic ask(int rank, int pend, int occ);
    send_word(pkso_pkg::REQ_QUERY, $urandom, 1'($urandom), pkso_pkg::RANK_W'(rank),
              pkso_pkg::PEND_W'(pend), pkso_pkg::OCC_W'(occ));
  endtask

  initial begin : stimulus
    int n_rand, len, nq, mode, r, v;
    bit restart;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a query on the empty array, then the value extremes with
    // duplicates, every way a query can be bad, zero and oversized occurrence.
    ask(1, 0, 1);
    load_value(32'h8000_0000, 1'b1);
    load_value(32'h7fff_ffff, 1'b0);
    load_value(32'h0000_0000, 1'b0);
    load_value(32'hffff_ffff, 1'b0);
    load_value(32'h7fff_ffff, 1'b0);
    load_value(32'h0000_0005, 1'b0);
    ask(0, 2, 1);      // rank zero
    ask(4, 2, 1);      // rank above prefix length
    ask(1, 6, 1);      // prefix end at the count
    ask(1, 5, 1);      // minimum, first copy
    ask(6, 5, 2);      // maximum, second copy further on
    ask(6, 5, 3);      // not that many copies
    ask(3, 3, 0);      // occurrence zero still reports the value
    ask(2, 1, 1);
    ask(1, 5, 1025);
    load_value(32'h0000_0007, 1'b1);   // restart with a single value
    ask(1, 0, 1);
    ask(1, 1, 1);

    // Pressure: stall the sink for a long stretch while queries keep coming,
    // so the output register fills and the block refuses further words.
    for (int i = 0; i < 8; i++) load_value(32'($urandom_range(7)) - 32'd3, i == 0);
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(7);
      ask($urandom_range(1, r + 1), r, $urandom_range(0, 3));
    end

    // Random: mostly short arrays followed by valid queries, with some
    // appends to the current array and some raw noise queries.
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      steady  = (n_rand >= 20 && n_rand < 45);
      restart = (sb.stored >= 40) || ($urandom_range(99) < 75);
      len     = $urandom_range(1, 24);
      mode    = $urandom_range(2);
      for (int j = 0; j < len; j++) begin
        case (mode)
          0: v = int'($urandom_range(6)) - 3;        // narrow pool, many repeats
          1: v = int'($urandom);
          default: begin
            case ($urandom_range(4))
              0: v = 32'h8000_0000;
              1: v = 32'h7fff_ffff;
              2: v = 0;
              3: v = -1;
              default: v = int'($urandom);
            endcase
          end
        endcase
        load_value(32'(v), restart && j == 0);
      end
      nq = $urandom_range(1, 4);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(99) < 15) begin
          ask($urandom_range(pkso_pkg::MAX_ELEMENTS), $urandom_range(pkso_pkg::MAX_ELEMENTS - 1),
              $urandom_range(1025));
        end else begin
          r = $urandom_range(sb.stored - 1);
          ask($urandom_range(1, r + 1), r,
              ($urandom_range(9) == 0) ? $urandom_range(1025) : $urandom_range(4));
        end
      end
      n_rand += len + nq;
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then idle a little longer to catch any stray answer word.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d load words and %0d queries: value extremes, restarts, a long sink stall.",
             sb.n_loads, sb.n_queries);
    $display("Answers: %0d found, %0d with no such occurrence, %0d rejected as bad.",
             sb.n_found, sb.n_missing, sb.n_bad);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
